FILE: src/input_event_remapper_top_macros.svh
// assertion macros for the input event remapper
// used by input_event_remapper_top; expects clk_i and rst_ni in scope
`ifndef INPUT_EVENT_REMAPPER_TOP_MACROS_SVH
`define INPUT_EVENT_REMAPPER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/iem_pkg.sv
// shared types and constants of the input event remapper
// used by iem_alu and input_event_remapper_top
package iem_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam int USAGE_W  = 11;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int GAIN_W   = 24;
  localparam int LEVEL_W  = 17;
  localparam int DEVICE_W = 4;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEVEL_W-1:0] HALF_LEVEL = 17'd32768;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'd65536;

  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    KIND_UNMAPPED = 2'd0,
    KIND_AXIS     = 2'd1,
    KIND_REL      = 2'd2,
    KIND_BUTTON   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [USAGE_W-1:0] source;
    kind_e              kind;
    logic               reverse;
    logic [GAIN_W-1:0]  gain;
    logic [LEVEL_W-1:0] level;
  } slot_t;

endpackage

FILE: src/iem_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module iem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/iem_alu.sv
// shared scaling unit: one multiply stage, then round, offset and clamp
// depends on iem_pkg
module iem_alu (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic signed [iem_pkg::VALUE_W-1:0] ev_i,
  input  iem_pkg::slot_t                   slot_i,
  output logic [iem_pkg::LEVEL_W-1:0]      level_o
);
  import iem_pkg::*;

  logic signed [33:0] ext_ev;
  logic signed [33:0] oper;
  logic signed [33:0] oper_sign;
  logic signed [24:0] gain_s;
  logic signed [58:0] prod_d;
  logic signed [58:0] prod_q;
  logic [LEVEL_W:0]   base_d;
  logic [LEVEL_W:0]   base_q;
  logic               pass_q;
  logic signed [VALUE_W-1:0] ev_q;
  logic signed [58:0] sum;
  logic signed [42:0] scaled;
  logic signed [42:0] value;

  // operand: axis values are centered on one half first
  assign ext_ev    = {{2{ev_i[VALUE_W-1]}}, ev_i};
  assign oper      = (slot_i.kind == KIND_AXIS) ? (ext_ev - 34'sd32768) : ext_ev;
  assign oper_sign = slot_i.reverse ? -oper : oper;
  assign gain_s    = {1'b0, slot_i.gain};
  assign prod_d    = oper_sign * gain_s;

  always_comb begin
    base_d = '0;
    case (slot_i.kind)
      KIND_AXIS: base_d = {1'b0, HALF_LEVEL};
      KIND_REL:  base_d = {1'b0, slot_i.level};
      default:   base_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      base_q <= base_d;
      pass_q <= (slot_i.kind == KIND_BUTTON);
      ev_q   <= ev_i;
    end
  end

  // rounding half and offset folded into one add ahead of the shift
  assign sum    = prod_q + $signed({25'd0, base_q, 16'h8000});
  assign scaled = sum[58:16];
  assign value  = pass_q ? 43'(ev_q) : scaled;

  always_comb begin
    if (value[42]) begin
      level_o = '0;
    end else if (value > 43'sd65536) begin
      level_o = FULL_LEVEL;
    end else begin
      level_o = value[LEVEL_W-1:0];
    end
  end

endmodule

FILE: src/input_event_remapper_top.sv
// input event remapper: slot table in ram, scan sequencer, output register
// a write word is taken while idle; an event word passes each slot through read and check,
// and a matching slot also through apply, then ends with a flush; output stalls can hold apply and flush
// one shared multiply/clamp unit processes the slots in index order; not ready while scanning
// reset clears all slot valid bits and device_id at once; no clearing pass
// depends on iem_pkg, iem_ram, iem_alu and input_event_remapper_top_macros.svh
`include "input_event_remapper_top_macros.svh"

module input_event_remapper_top #(
  parameter int SLOTS = iem_pkg::SLOTS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [iem_pkg::DEVICE_W-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // source_usage, event_value, slot_index, slot_source, slot_kind, slot_reverse,
  // slot_gain, zero pad
  input  logic [iem_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_device, out_usage, out_level, zero pad
  output logic [iem_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import iem_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPLY,
    S_FLUSH
  } state_e;

  // input word fields
  logic [USAGE_W-1:0]        in_source;
  logic signed [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0]        in_index;
  slot_t                     in_slot;

  assign in_source     = s_axis_tdata_i[10:0];
  assign in_value      = s_axis_tdata_i[42:11];
  assign in_index      = s_axis_tdata_i[47:43];
  assign in_slot.source  = s_axis_tdata_i[58:48];
  assign in_slot.kind    = kind_e'(s_axis_tdata_i[60:59]);
  assign in_slot.reverse = s_axis_tdata_i[61];
  assign in_slot.gain    = s_axis_tdata_i[85:62];
  assign in_slot.level   = HALF_LEVEL;

  state_e                    state_q, state_d;
  logic [SLOTS-1:0]          valid_q;
  logic [IDX_W-1:0]          idx_q;
  logic [USAGE_W-1:0]        src_q;
  logic signed [VALUE_W-1:0] ev_q;
  logic [DEVICE_W-1:0]       device_q;
  logic                      pend_valid_q;
  logic [INDEX_W-1:0]        pend_usage_q;
  logic [LEVEL_W-1:0]        pend_level_q;
  logic                      out_valid_q;
  logic                      out_last_q;
  logic [DEVICE_W-1:0]       out_device_q;
  logic [INDEX_W-1:0]        out_usage_q;
  logic [LEVEL_W-1:0]        out_level_q;

  logic        in_accept;
  logic        wr_item;
  logic        wr_in_range;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t       ram_wdata;
  slot_t       ram_rdata;
  logic        alu_load;
  logic [LEVEL_W-1:0] alu_level;
  logic        slot_match;
  logic        changed;
  logic        out_free;
  logic        can_push;
  logic        last_slot;
  logic        apply_go;
  logic        flush_go;
  logic        out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_item     = in_accept && (s_axis_tuser_i == ACT_WRITE);
  assign wr_in_range = (32'(in_index) < SLOTS);

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign can_push  = !pend_valid_q || out_free;
  assign last_slot = (idx_q == IDX_W'(SLOTS - 1));

  assign slot_match = valid_q[idx_q] && (ram_rdata.source == src_q) &&
                      (ram_rdata.kind != KIND_UNMAPPED);
  assign alu_load   = (state_q == S_CHECK) && slot_match;
  assign changed    = (alu_level != ram_rdata.level);
  assign apply_go   = (state_q == S_APPLY) && changed && can_push;
  assign flush_go   = (state_q == S_FLUSH) && pend_valid_q && out_free;
  // the pending word moves to the output register
  assign out_load   = (apply_go && pend_valid_q) || flush_go;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    if (state_q == S_IDLE) begin
      ram_we    = wr_item && wr_in_range;
      ram_waddr = IDX_W'(in_index);
      ram_wdata = in_slot;
    end else begin
      ram_we          = apply_go;
      ram_wdata.level = alu_level;
    end
  end

  iem_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  iem_alu u_alu (
    .clk_i   (clk_i),
    .load_i  (alu_load),
    .ev_i    (ev_q),
    .slot_i  (ram_rdata),
    .level_o (alu_level)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (s_axis_tuser_i == ACT_EVENT)) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (slot_match) begin
          state_d = S_APPLY;
        end else begin
          state_d = last_slot ? S_FLUSH : S_READ;
        end
      end
      S_APPLY: begin
        if (!changed || can_push) begin
          state_d = last_slot ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      src_q        <= '0;
      ev_q         <= '0;
      device_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_usage_q <= '0;
      pend_level_q <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_device_q <= '0;
      out_usage_q  <= '0;
      out_level_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        device_q <= cfg_wdata_i;
      end
      if (state_q == S_IDLE) begin
        idx_q <= '0;
        if (in_accept) begin
          src_q <= in_source;
          ev_q  <= in_value;
        end
        if (wr_item && wr_in_range) begin
          valid_q[IDX_W'(in_index)] <= 1'b1;
        end
      end
      // step to the next slot
      if (((state_q == S_CHECK) && !slot_match) ||
          ((state_q == S_APPLY) && (!changed || can_push))) begin
        if (!last_slot) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      // a changed level is held back until the next one shows whether it is last
      if (apply_go) begin
        pend_valid_q <= 1'b1;
        pend_usage_q <= INDEX_W'(idx_q);
        pend_level_q <= alu_level;
      end
      if (flush_go) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_last_q   <= flush_go;
        out_device_q <= device_q;
        out_usage_q  <= pend_usage_q;
        out_level_q  <= pend_level_q;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_level_q, out_usage_q, out_device_q};

  `IEM_ASSERT_NOW(a_idle_no_pending, state_q == S_IDLE, !pend_valid_q, "pending word left at idle")
  `IEM_ASSERT_NOW(a_level_in_range, out_valid_q, out_level_q <= FULL_LEVEL, "level above one")
  `IEM_ASSERT_NOW(a_usage_in_range, out_valid_q, 32'(out_usage_q) < SLOTS, "usage beyond table")
  `IEM_ASSERT_NEXT(a_event_starts_scan, in_accept && (s_axis_tuser_i == ACT_EVENT),
                   (state_q == S_READ) && (idx_q == '0), "event did not start a scan")

endmodule
